// ===== src/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion helpers for the oscillator RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable
`define ASSERT_AT(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) \
        else $error(msg);

// Same, on the module's clk and rst_n
`define ASSERT_CLK(label, prop, msg) `ASSERT_AT(label, clk, rst_n, prop, msg)

`endif

// ===== src/lfo_pkg.sv =====
// ============================================================================
// LFO package
// Types, codes and helper functions shared by the oscillator modules.
// ============================================================================
package lfo_pkg;

    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_GATE        = 2'd1;
    localparam logic [1:0] OP_PHASE_RESET = 2'd2;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_HOLD     = 3'd4;

    localparam logic [1:0] RUN_ALWAYS   = 2'd0;
    localparam logic [1:0] RUN_GATED    = 2'd1;
    localparam logic [1:0] RUN_ONE_SHOT = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIPOLAR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 3'd5;

    localparam logic [15:0] DEPTH_FULL = 16'd32768;

    // raw waveform value, -32768 .. 32768
    localparam int RAW_W = 17;

    typedef struct packed {
        logic [1:0] op;
        logic       gate_level;
    } lfo_item_t;

    typedef struct packed {
        logic signed [15:0] wave_out;
        logic               is_running;
    } lfo_result_t;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [15:0] depth;
        logic [2:0]  waveform;
        logic        bipolar;
        logic [1:0]  run_mode;
    } lfo_cfg_t;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } lfo_cfg_wr_t;

    typedef struct packed {
        logic               valid;
        logic               tick;
        logic               running;
        logic [15:0]        frac;
        logic signed [15:0] held;
    } lfo_s1_t;

    typedef struct packed {
        logic                    valid;
        logic                    tick;
        logic                    running;
        logic signed [RAW_W-1:0] raw;
    } lfo_s2_t;

    function automatic logic [1:0] norm_run_mode(input logic [1:0] mode);
        return (mode > RUN_ONE_SHOT) ? RUN_ONE_SHOT : mode;
    endfunction

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // Quarter-wave sine point, odd polynomial in Q16, rounded to Q15
    function automatic logic [15:0] quarter_sine(input int unsigned k,
                                                 input int unsigned shift);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x3;
        longint unsigned x5;
        longint unsigned y;
        longint unsigned r;
        x  = k;
        x  = x << shift;
        x2 = (x * x) >> 16;
        x3 = (x2 * x) >> 16;
        x5 = (x3 * x2) >> 16;
        y  = 64'd102944 * x - 64'd42047 * x3 + 64'd4640 * x5;
        r  = (y + 64'd65536) >> 17;
        if (r > 64'd32768)
        begin
            r = 64'd32768;
        end
        return r[15:0];
    endfunction

endpackage

// ===== src/lfo_core.sv =====
// ============================================================================
// LFO core
// Phase accumulator, xorshift sample generator and run/gate control.
// ============================================================================
module lfo_core #(
    parameter int PHASE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                acc,
    input  lfo_pkg::lfo_item_t  item,
    input  lfo_pkg::lfo_cfg_t   cfg,
    input  lfo_pkg::lfo_cfg_wr_t cfg_wr,
    output lfo_pkg::lfo_s1_t    s1
);

    localparam logic [32:0] PH_MAX = (33'd1 << PHASE_BITS) - 33'd1;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [31:0]           rng_reg, rng_next;
    logic signed [15:0]    held_reg, held_next;
    logic                  running_reg, running_next;
    logic                  last_gate_reg, last_gate_next;
    lfo_pkg::lfo_s1_t      s1_reg;

    logic [PHASE_BITS-1:0] step_sat;
    logic [PHASE_BITS:0]   sum;
    logic [31:0]           rng_drawn;
    logic [1:0]            mode_w;

    assign step_sat  = ({1'b0, cfg.phase_step} > PH_MAX) ? PH_MAX[PHASE_BITS-1:0]
                                                        : cfg.phase_step[PHASE_BITS-1:0];
    assign sum       = {1'b0, phase_reg} + {1'b0, step_sat};
    assign rng_drawn = lfo_pkg::xorshift32(rng_reg);
    assign mode_w    = lfo_pkg::norm_run_mode(cfg_wr.data[1:0]);

    always_comb
    begin
        phase_next     = phase_reg;
        rng_next       = rng_reg;
        held_next      = held_reg;
        running_next   = running_reg;
        last_gate_next = last_gate_reg;
        if (cfg_wr.en)
        begin
            case (cfg_wr.index)
                lfo_pkg::REG_RUN_MODE:
                begin
                    case (mode_w)
                        lfo_pkg::RUN_ALWAYS: running_next = 1'b1;
                        lfo_pkg::RUN_GATED:  running_next = last_gate_reg;
                        default:             running_next = 1'b0;
                    endcase
                end
                lfo_pkg::REG_RANDOM_SEED:
                begin
                    rng_next = (cfg_wr.data == 32'd0) ? 32'd1 : cfg_wr.data;
                end
                default:
                begin
                end
            endcase
        end
        else if (acc)
        begin
            case (item.op)
                lfo_pkg::OP_TICK:
                begin
                    if (running_reg)
                    begin
                        phase_next = sum[PHASE_BITS-1:0];
                        if (sum[PHASE_BITS])
                        begin
                            rng_next  = rng_drawn;
                            held_next = {~rng_drawn[31], rng_drawn[30:16]};
                            if (cfg.run_mode == lfo_pkg::RUN_ONE_SHOT)
                            begin
                                running_next = 1'b0;
                            end
                        end
                    end
                end
                lfo_pkg::OP_GATE:
                begin
                    last_gate_next = item.gate_level;
                    if (cfg.run_mode == lfo_pkg::RUN_GATED)
                    begin
                        running_next = item.gate_level;
                    end
                    else if (cfg.run_mode == lfo_pkg::RUN_ONE_SHOT
                             && item.gate_level && !last_gate_reg)
                    begin
                        running_next = 1'b1;
                        phase_next   = '0;
                    end
                end
                lfo_pkg::OP_PHASE_RESET:
                begin
                    phase_next = '0;
                    rng_next   = rng_drawn;
                    held_next  = {~rng_drawn[31], rng_drawn[30:16]};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            rng_reg       <= 32'd1;
            held_reg      <= '0;
            running_reg   <= 1'b1;
            last_gate_reg <= 1'b0;
            s1_reg        <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rng_reg       <= rng_next;
            held_reg      <= held_next;
            running_reg   <= running_next;
            last_gate_reg <= last_gate_next;
            if (adv)
            begin
                s1_reg.valid   <= acc;
                s1_reg.tick    <= (item.op == lfo_pkg::OP_TICK);
                s1_reg.running <= running_next;
                s1_reg.frac    <= phase_next[PHASE_BITS-1 -: 16];
                s1_reg.held    <= held_next;
            end
        end
    end

    assign s1 = s1_reg;

endmodule

// ===== src/lfo_wave.sv =====
// ============================================================================
// LFO waveform stage
// Turns the phase fraction, or the held sample, into a raw Q2.15 waveform value.
// ============================================================================
module lfo_wave #(
    parameter int SINE_INDEX_BITS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [2:0]       waveform,
    input  lfo_pkg::lfo_s1_t s1,
    output lfo_pkg::lfo_s2_t s2
);

    localparam int QB    = SINE_INDEX_BITS - 2;
    localparam int QSIZE = 1 << QB;
    localparam logic [QB:0] QSIZE_V = {1'b1, {QB{1'b0}}};

    logic [15:0] sine_rom [QSIZE+1];

    for (genvar k = 0; k <= QSIZE; k++)
    begin : g_rom
        assign sine_rom[k] = lfo_pkg::quarter_sine(k, 18 - SINE_INDEX_BITS);
    end

    logic [SINE_INDEX_BITS-1:0]      idx;
    logic [1:0]                      quad;
    logic [QB:0]                     k_sel;
    logic signed [lfo_pkg::RAW_W-1:0] sine_pos;
    logic signed [lfo_pkg::RAW_W-1:0] sine_val;
    logic signed [17:0]              f2;
    logic signed [17:0]              tri18;
    logic signed [lfo_pkg::RAW_W-1:0] raw;
    lfo_pkg::lfo_s2_t                s2_reg;

    assign idx      = s1.frac[15 -: SINE_INDEX_BITS];
    assign quad     = idx[SINE_INDEX_BITS-1 -: 2];
    assign k_sel    = quad[0] ? (QSIZE_V - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
    assign sine_pos = $signed({1'b0, sine_rom[k_sel]});
    assign sine_val = quad[1] ? -sine_pos : sine_pos;
    assign f2       = $signed({1'b0, s1.frac, 1'b0});
    assign tri18    = s1.frac[15] ? (18'sd98304 - f2) : (f2 - 18'sd32768);

    always_comb
    begin
        case (waveform)
            lfo_pkg::WAVE_SINE:     raw = sine_val;
            lfo_pkg::WAVE_TRIANGLE: raw = tri18[lfo_pkg::RAW_W-1:0];
            lfo_pkg::WAVE_SAW:      raw = $signed({~s1.frac[15], ~s1.frac[15],
                                                   s1.frac[14:0]});
            lfo_pkg::WAVE_SQUARE:   raw = s1.frac[15] ? -17'sd32768 : 17'sd32768;
            default:                raw = $signed({s1.held[15], s1.held});
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s2_reg.valid   <= s1.valid;
            s2_reg.tick    <= s1.tick;
            s2_reg.running <= s1.running;
            s2_reg.raw     <= raw;
        end
    end

    assign s2 = s2_reg;

endmodule

// ===== src/lfo_shape.sv =====
// ============================================================================
// LFO shaping stage
// Depth scaling, saturation and the result register.
// ============================================================================
module lfo_shape (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic [15:0]          depth,
    input  logic                 bipolar,
    input  lfo_pkg::lfo_s2_t     s2,
    output logic                 result_valid,
    output lfo_pkg::lfo_result_t result
);

    logic [15:0]        depth_c;
    logic signed [17:0] raw_ext;
    logic signed [17:0] a_op;
    logic signed [16:0] d_op;
    logic signed [34:0] prod;
    logic signed [34:0] scaled;
    logic signed [15:0] sat;

    logic               out_valid_reg;
    logic signed [15:0] out_value_reg;
    logic               out_running_reg;

    assign depth_c = (depth > lfo_pkg::DEPTH_FULL) ? lfo_pkg::DEPTH_FULL : depth;
    assign raw_ext = {s2.raw[lfo_pkg::RAW_W-1], s2.raw};
    assign a_op    = bipolar ? raw_ext : (raw_ext + 18'sd32768);
    assign d_op    = $signed({1'b0, depth_c});
    assign prod    = a_op * d_op;
    assign scaled  = bipolar ? ((prod + 35'sd16384) >>> 15) : ((prod + 35'sd32768) >>> 16);

    always_comb
    begin
        if (scaled > 35'sd32767)
        begin
            sat = 16'sd32767;
        end
        else if (scaled < -35'sd32768)
        begin
            sat = -16'sd32768;
        end
        else
        begin
            sat = scaled[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_value_reg   <= '0;
            out_running_reg <= 1'b1;
        end
        else if (adv)
        begin
            out_valid_reg <= s2.valid;
            if (s2.valid)
            begin
                out_running_reg <= s2.running;
                if (s2.tick)
                begin
                    out_value_reg <= sat;
                end
            end
        end
    end

    assign result_valid      = out_valid_reg;
    assign result.wave_out   = out_value_reg;
    assign result.is_running = out_running_reg;

endmodule

// ===== src/low_frequency_oscillator.sv =====
// ============================================================================
// Low-frequency oscillator
// Phase-accumulator LFO with sine, triangle, saw, square and sample-and-hold.
// ============================================================================
// Takes one transaction per clock while the result side does not stall and
// returns exactly one result per transaction, registered in the core, wave
// and shape stages in turn. The accumulator and random generator update in
// the accept cycle; the waveform table lookup and the depth multiply each
// take one pipeline stage. A stall on the result side holds the whole
// pipeline and stalls the input. Configuration writes are always ready and
// must only be issued while no transaction is in flight.
`include "assert_macros.svh"

module low_frequency_oscillator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_INDEX_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  lfo_pkg::lfo_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output lfo_pkg::lfo_result_t                result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data
);

    lfo_pkg::lfo_cfg_t    cfg_reg;
    lfo_pkg::lfo_cfg_wr_t cfg_wr;
    lfo_pkg::lfo_s1_t     s1;
    lfo_pkg::lfo_s2_t     s2;
    logic                 adv;
    logic                 acc;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.en    = cfg_valid & cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign adv        = !result_valid || !result_stall;
    assign item_stall = !adv;
    assign acc        = item_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step <= '0;
            cfg_reg.depth      <= lfo_pkg::DEPTH_FULL;
            cfg_reg.waveform   <= lfo_pkg::WAVE_SINE;
            cfg_reg.bipolar    <= 1'b1;
            cfg_reg.run_mode   <= lfo_pkg::RUN_ALWAYS;
        end
        else if (cfg_wr.en)
        begin
            case (cfg_wr.index)
                lfo_pkg::REG_PHASE_STEP: cfg_reg.phase_step <= cfg_wr.data;
                lfo_pkg::REG_DEPTH:      cfg_reg.depth      <= cfg_wr.data[15:0];
                lfo_pkg::REG_WAVEFORM:   cfg_reg.waveform   <= cfg_wr.data[2:0];
                lfo_pkg::REG_BIPOLAR:    cfg_reg.bipolar    <= cfg_wr.data[0];
                lfo_pkg::REG_RUN_MODE:
                    cfg_reg.run_mode <= lfo_pkg::norm_run_mode(cfg_wr.data[1:0]);
                default:
                begin
                end
            endcase
        end
    end

    lfo_core #(
        .PHASE_BITS(PHASE_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .acc   (acc),
        .item  (item),
        .cfg   (cfg_reg),
        .cfg_wr(cfg_wr),
        .s1    (s1)
    );

    lfo_wave #(
        .SINE_INDEX_BITS(SINE_INDEX_BITS)
    ) u_wave (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .waveform(cfg_reg.waveform),
        .s1      (s1),
        .s2      (s2)
    );

    lfo_shape u_shape (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .depth       (cfg_reg.depth),
        .bipolar     (cfg_reg.bipolar),
        .s2          (s2),
        .result_valid(result_valid),
        .result      (result)
    );

    `ASSERT_CLK(a_phase_reset_zero, (acc && item.op == lfo_pkg::OP_PHASE_RESET) |=> (s1.frac == 16'd0), "phase reset did not clear phase")
    `ASSERT_CLK(a_always_runs, (s1.valid && cfg_reg.run_mode == lfo_pkg::RUN_ALWAYS) |-> s1.running, "oscillator stopped in always mode")
    `ASSERT_CLK(a_result_follows, (s2.valid && adv) |=> result_valid, "pipeline dropped a transaction")
    `ASSERT_CLK(a_non_tick_holds, (adv && s2.valid && !s2.tick) |=> $stable(result.wave_out), "non-tick transaction changed output value")

endmodule

// ===== test/tb_low_frequency_oscillator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Low-frequency oscillator testbench
// A directed table covers reset values, extreme depths and steps, every
// waveform and run mode, and the odd codes. Random phases follow, each with
// fresh register settings and random tick, gate and phase-reset traffic.
// Bursty input and a stalling output side run throughout. Every result is
// compared field by field with a table value or an in-bench oscillator model.
// ============================================================================
module tb_low_frequency_oscillator;
    import lfo_pkg::*;

    localparam int SINE_IDX = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES = 8;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [1:0] RUN_MODE_SPARE = 2'd3;
    localparam logic [2:0] WAVE_SPARE = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        lfo_item_t            it;
        lfo_result_t          want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    lfo_item_t            item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    lfo_result_t          result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // oscillator state and register copies
    logic [31:0]        acc_phase = '0;
    logic [31:0]        rand_reg = 32'd1;
    logic signed [15:0] hold_val = '0;
    logic               run_flag = 1'b1;
    logic               gate_prev = 1'b0;
    logic signed [15:0] out_val = '0;
    logic [31:0]        cfg_step = '0;
    logic [15:0]        cfg_depth = DEPTH_FULL;
    logic [2:0]         cfg_wave = WAVE_SINE;
    logic               cfg_bip = 1'b1;
    logic [1:0]         cfg_mode = RUN_ALWAYS;

    lfo_result_t pending_outputs[$];
    plan_row_t   plan[$];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_draws = 0;
    int quiet = 0;
    bit held_off = 1'b0;

    low_frequency_oscillator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void draw_held();
        logic [31:0] x;
        x = rand_reg;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rand_reg = x;
        hold_val = x[31:16] - 16'h8000;
        n_draws++;
    endfunction

    function automatic lfo_result_t next_output(input lfo_item_t it);
        logic [32:0]       sum;
        logic              rising;
        logic [15:0]       f;
        logic [SINE_IDX-1:0] idx;
        int unsigned       k;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   x3;
        longint unsigned   x5;
        longint unsigned   y;
        int                raw;
        longint            d;
        longint            v;
        lfo_result_t       res;
        case (it.op)
            OP_TICK:
            begin
                if (run_flag)
                begin
                    sum = {1'b0, acc_phase} + {1'b0, cfg_step};
                    acc_phase = sum[31:0];
                    if (sum[32])
                    begin
                        draw_held();
                        if (cfg_mode == RUN_ONE_SHOT)
                        begin
                            run_flag = 1'b0;
                        end
                    end
                end
                f = acc_phase[31:16];
                case (cfg_wave)
                    WAVE_SINE:
                    begin
                        // quarter-wave lookup mirrored per quadrant
                        idx = acc_phase[31:32-SINE_IDX];
                        k = idx[SINE_IDX-3:0];
                        if (idx[SINE_IDX-2])
                        begin
                            k = (1 << (SINE_IDX - 2)) - k;
                        end
                        x = k;
                        x = x << (18 - SINE_IDX);
                        x2 = (x * x) >> 16;
                        x3 = (x2 * x) >> 16;
                        x5 = (x3 * x2) >> 16;
                        y = 64'd102944 * x - 64'd42047 * x3 + 64'd4640 * x5;
                        y = (y + 64'd65536) >> 17;
                        if (y > 64'd32768)
                        begin
                            y = 64'd32768;
                        end
                        raw = idx[SINE_IDX-1] ? -int'(y) : int'(y);
                    end
                    WAVE_TRIANGLE:
                        raw = (f < 16'h8000) ? 2 * int'(f) - 32768 : 98304 - 2 * int'(f);
                    WAVE_SAW:
                        raw = int'(f) - 32768;
                    WAVE_SQUARE:
                        raw = (f < 16'h8000) ? 32768 : -32768;
                    default:
                        raw = hold_val;
                endcase
                d = (cfg_depth > DEPTH_FULL) ? longint'(DEPTH_FULL) : longint'(cfg_depth);
                if (cfg_bip)
                begin
                    v = (longint'(raw) * d + 16384) >>> 15;
                end
                else
                begin
                    v = ((longint'(raw) + 32768) * d + 32768) >>> 16;
                end
                if (v > 32767)
                begin
                    v = 32767;
                end
                if (v < -32768)
                begin
                    v = -32768;
                end
                out_val = v[15:0];
            end
            OP_GATE:
            begin
                rising = it.gate_level && !gate_prev;
                gate_prev = it.gate_level;
                if (cfg_mode == RUN_GATED)
                begin
                    run_flag = it.gate_level;
                end
                else if (cfg_mode == RUN_ONE_SHOT && rising)
                begin
                    run_flag = 1'b1;
                    acc_phase = '0;
                end
            end
            OP_PHASE_RESET:
            begin
                acc_phase = '0;
                draw_held();
            end
            default:
            begin
            end
        endcase
        res.wave_out = out_val;
        res.is_running = run_flag;
        return res;
    endfunction

    function automatic void plan_item(input logic [1:0] op, input logic gate);
        plan_row_t row;
        row.kind = ROW_ITEM;
        row.idx = '0;
        row.data = '0;
        row.it.op = op;
        row.it.gate_level = gate;
        row.want = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_checked(input logic [1:0] op, input logic gate,
                                         input logic signed [15:0] wave, input logic run);
        plan_row_t row;
        row.kind = ROW_CHECKED;
        row.idx = '0;
        row.data = '0;
        row.it.op = op;
        row.it.gate_level = gate;
        row.want.wave_out = wave;
        row.want.is_running = run;
        plan.push_back(row);
    endfunction

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        plan_row_t row;
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        row.it = '0;
        row.want = '0;
        plan.push_back(row);
    endfunction

    // leaves item_valid high; the caller lowers it when a gap follows
    task automatic push_item(input lfo_item_t it, input bit typed, input lfo_result_t want);
        lfo_result_t predicted;
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        predicted = next_output(it);
        pending_outputs.push_back(typed ? want : predicted);
        n_items++;
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_PHASE_STEP:  cfg_step = data;
            REG_DEPTH:       cfg_depth = data[15:0];
            REG_WAVEFORM:    cfg_wave = data[2:0];
            REG_BIPOLAR:     cfg_bip = data[0];
            REG_RUN_MODE:
            begin
                cfg_mode = (data[1:0] == RUN_MODE_SPARE) ? RUN_ONE_SHOT : data[1:0];
                run_flag = (cfg_mode == RUN_ALWAYS) ? 1'b1 :
                           (cfg_mode == RUN_GATED) ? gate_prev : 1'b0;
            end
            REG_RANDOM_SEED: rand_reg = (data == '0) ? 32'd1 : data;
            default:
            begin
            end
        endcase
        n_writes++;
    endtask

    task automatic wait_idle();
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // result side: stall patterns, plus one long hold-off
    initial
    begin
        int mode;
        int seg;
        int cnt;
        cnt = 0;
        wait (rst_n);
        forever
        begin
            if (!held_off && n_items > 700)
            begin
                held_off = 1'b1;
                @(posedge clk);
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            seg = $urandom_range(20, 200);
            repeat (seg)
            begin
                @(posedge clk);
                cnt++;
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ($urandom_range(0, 1) == 0);
                    default: result_stall <= ((cnt % 7) < 3);
                endcase
            end
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        lfo_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (pending_outputs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, got %0d / %0b",
                             $time, result.wave_out, result.is_running);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (result.wave_out !== want.wave_out)
                    begin
                        errors++;
                        $display("%0t: wave_out expected %0d got %0d",
                                 $time, want.wave_out, result.wave_out);
                    end
                    if (result.is_running !== want.is_running)
                    begin
                        errors++;
                        $display("%0t: is_running expected %0b got %0b",
                                 $time, want.is_running, result.is_running);
                    end
                end
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet <= 0;
            end
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, quiet);
                $display("low_frequency_oscillator: mismatch");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    initial
    begin
        plan_row_t   row;
        lfo_item_t   it;
        lfo_result_t none;
        int          burst;
        int          n;
        logic [31:0] data;

        none = '0;

        // reset state: sine, full depth, step zero
        plan_checked(OP_TICK, 1'b0, 16'sd0, 1'b1);
        plan_checked(OP_SPARE, 1'b1, 16'sd0, 1'b1);
        plan_reg(REG_WAVEFORM, 32'(WAVE_SQUARE));
        plan_checked(OP_TICK, 1'b0, 16'sd32767, 1'b1);
        plan_reg(REG_WAVEFORM, 32'(WAVE_SAW));
        plan_checked(OP_TICK, 1'b0, -16'sd32768, 1'b1);
        plan_reg(REG_DEPTH, 32'd0);
        plan_checked(OP_TICK, 1'b0, 16'sd0, 1'b1);
        // depth above full scale
        plan_reg(REG_DEPTH, 32'hFFFF_FFFF);
        plan_checked(OP_TICK, 1'b0, -16'sd32768, 1'b1);
        plan_reg(REG_BIPOLAR, 32'd0);
        plan_checked(OP_TICK, 1'b0, 16'sd0, 1'b1);
        plan_reg(REG_WAVEFORM, 32'(WAVE_SQUARE));
        plan_checked(OP_TICK, 1'b0, 16'sd32767, 1'b1);
        // out-of-range waveform code, zero seed
        plan_reg(REG_WAVEFORM, 32'(WAVE_SPARE));
        plan_item(OP_TICK, 1'b0);
        plan_reg(REG_RANDOM_SEED, 32'd0);
        plan_item(OP_PHASE_RESET, 1'b1);
        plan_item(OP_TICK, 1'b0);
        // largest step: carry on nearly every tick
        plan_reg(REG_BIPOLAR, 32'd1);
        plan_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        plan_reg(REG_WAVEFORM, 32'(WAVE_TRIANGLE));
        plan_item(OP_TICK, 1'b0);
        plan_item(OP_TICK, 1'b0);
        // spare run mode code, one-shot retrigger
        plan_reg(REG_RUN_MODE, 32'(RUN_MODE_SPARE));
        plan_item(OP_TICK, 1'b0);
        plan_item(OP_GATE, 1'b1);
        plan_item(OP_TICK, 1'b0);
        plan_item(OP_TICK, 1'b0);
        plan_item(OP_GATE, 1'b0);
        plan_reg(REG_RUN_MODE, 32'(RUN_GATED));
        plan_item(OP_GATE, 1'b1);
        plan_item(OP_TICK, 1'b0);
        plan_item(OP_GATE, 1'b0);
        // gate while free-running
        plan_reg(REG_RUN_MODE, 32'(RUN_ALWAYS));
        plan_item(OP_GATE, 1'b1);
        plan_item(OP_TICK, 1'b0);
        plan_reg(REG_WAVEFORM, 32'(WAVE_SINE));
        plan_reg(REG_PHASE_STEP, 32'h3000_0000);
        plan_item(OP_TICK, 1'b0);
        plan_item(OP_TICK, 1'b0);
        plan_item(OP_TICK, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_REG)
            begin
                item_valid <= 1'b0;
                wait_idle();
                write_reg(row.idx, row.data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                push_item(row.it, row.kind == ROW_CHECKED, row.want);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            item_valid <= 1'b0;
            wait_idle();
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_SPARE, $urandom);
            end
            case ($urandom_range(0, 5))
                0: data = 32'd0;
                1: data = 32'hFFFF_FFFF;
                2: data = $urandom;
                3: data = 32'd1 << $urandom_range(20, 31);
                4: data = $urandom_range(32'h0000_0100, 32'h0100_0000);
                default: data = $urandom_range(32'h0100_0000, 32'h2000_0000);
            endcase
            write_reg(REG_PHASE_STEP, data);
            case ($urandom_range(0, 4))
                0: data = $urandom & 32'hFFFF_0000;
                1: data = 32'(DEPTH_FULL);
                2: data = $urandom | 32'h0000_FFFF;
                3: data = $urandom_range(0, 32768);
                default: data = $urandom;
            endcase
            write_reg(REG_DEPTH, data);
            write_reg(REG_WAVEFORM, $urandom);
            write_reg(REG_BIPOLAR, $urandom);
            write_reg(REG_RANDOM_SEED, ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom);
            write_reg(REG_RUN_MODE, $urandom);
            cfg_valid <= 1'b0;

            n = $urandom_range(150, 240);
            burst = $urandom_range(0, 40);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:    it.op = OP_GATE;
                    3, 4:       it.op = OP_PHASE_RESET;
                    5:          it.op = OP_SPARE;
                    default:    it.op = OP_TICK;
                endcase
                it.gate_level = $urandom_range(0, 1);
                push_item(it, 1'b0, none);
                if (burst == 0)
                begin
                    item_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                    burst = $urandom_range(0, 40);
                end
                else
                begin
                    burst--;
                end
            end
        end

        item_valid <= 1'b0;
        wait_idle();
        repeat (20) @(posedge clk);
        $display("Ran %0d transactions (%0d results checked) over %0d register writes,",
                 n_items, n_results, n_writes);
        $display("with %0d sample draws and a %0d-cycle output hold-off.",
                 n_draws, HOLD_OFF_CYCLES);
        if (errors == 0)
        begin
            $display("low_frequency_oscillator: match");
        end
        else
        begin
            $display("low_frequency_oscillator: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/lfo_pkg.sv
src/lfo_core.sv
src/lfo_wave.sv
src/lfo_shape.sv
src/low_frequency_oscillator.sv
test/tb_low_frequency_oscillator.sv
